// File: sv/fixed_length_frame_receiver_assert.svh
// assertion macros for the receiver modules, used by flrx_ctrl
`ifndef FIXED_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`define FIXED_LENGTH_FRAME_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF
`define FLRX_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FLRX_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define FLRX_ASSERT(lbl, clk, rst, prop, msg)
`define FLRX_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

// File: sv/flrx_pkg.sv
package flrx_pkg;

   localparam int unsigned FRAME_LEN = 100;
   localparam int unsigned ADDR_W    = $clog2(FRAME_LEN);
   localparam int unsigned FILL_W    = ADDR_W;
   localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(FRAME_LEN - 1);

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic REG_HEAD = 1'b0;
   localparam logic REG_TAIL = 1'b1;

   localparam logic [7:0] HEAD_RESET = 8'd85;
   localparam logic [7:0] TAIL_RESET = 8'd10;

   typedef enum logic [1:0] {
      OP_RECV    = 2'd0,
      OP_READ    = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef struct packed {
      logic [7:0] head;
      logic [7:0] tail;
   } cfg_type;

   // one beat in flight between the state stage and the output register
   typedef struct packed {
      logic valid;
      logic accepted;
      logic dropped;
      logic ready;
      logic rd_hit;
      logic rd_bank;
   } stage_type;

endpackage

// File: sv/flrx_if.sv
interface flrx_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] rx_byte;
   logic [6:0] read_index;

   modport source (output valid, output operation, output rx_byte, output read_index,
                   input ready);
   modport sink   (input valid, input operation, input rx_byte, input read_index,
                   output ready);
endinterface

interface flrx_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_accepted;
   logic       frame_dropped;
   logic [7:0] read_data;
   logic       packet_ready;

   modport source (output valid, output frame_accepted, output frame_dropped,
                   output read_data, output packet_ready, input ready);
   modport sink   (input valid, input frame_accepted, input frame_dropped,
                   input read_data, input packet_ready, output ready);
endinterface

// File: sv/flrx_ram.sv
module flrx_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/flrx_csr.sv
module flrx_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [flrx_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [flrx_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [flrx_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output flrx_pkg::cfg_type                   cfg
);
   import flrx_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_HEAD: cfg_in.head = csr_pwdata[7:0];
            REG_TAIL: cfg_in.tail = csr_pwdata[7:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_HEAD: csr_prdata = {(CSR_DATA_W - 8)'(0), cfg_ff.head};
         REG_TAIL: csr_prdata = {(CSR_DATA_W - 8)'(0), cfg_ff.tail};
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head <= HEAD_RESET;
         cfg_ff.tail <= TAIL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/flrx_ctrl.sv
`include "fixed_length_frame_receiver_assert.svh"

module flrx_ctrl (
   input  logic                clock,
   input  logic                reset,
   flrx_req_if.sink            req,
   input  flrx_pkg::cfg_type   cfg,
   input  logic                advance,
   output flrx_pkg::stage_type stage,
   output logic [7:0]          rdata0,
   output logic [7:0]          rdata1
);
   import flrx_pkg::*;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              bank_ff, bank_in;   // bank being filled; the other one is held
   logic              rdy_ff, rdy_in;
   stage_type         s1_ff, s1_in;

   logic              accept;
   logic              acc, drp, we, hit;
   logic              in_range;
   logic [ADDR_W-1:0] raddr;

   assign req.ready = !reset && (!s1_ff.valid || advance);
   assign accept    = req.valid && req.ready;
   assign in_range  = 32'(req.read_index) < FRAME_LEN;
   assign raddr     = ADDR_W'(req.read_index);

   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      rdy_in  = rdy_ff;
      acc     = 1'b0;
      drp     = 1'b0;
      we      = 1'b0;
      hit     = 1'b0;
      if (accept) begin
         case (req.operation)
            OP_RECV: begin
               if (fill_ff == '0 && req.rx_byte != cfg.head) begin
                  drp = 1'b1;
               end else begin
                  we = 1'b1;
                  if (fill_ff == LAST_FILL) begin
                     fill_in = '0;
                     if (req.rx_byte == cfg.tail) begin
                        acc     = 1'b1;
                        rdy_in  = 1'b1;
                        bank_in = ~bank_ff;   // swap instead of copying
                     end else begin
                        drp = 1'b1;
                     end
                  end else begin
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end
            OP_READ:    hit    = in_range;
            OP_RELEASE: rdy_in = 1'b0;
            default:    ;
         endcase
      end
   end

   always_comb begin
      s1_in = s1_ff;
      if (accept) begin
         s1_in.valid    = 1'b1;
         s1_in.accepted = acc;
         s1_in.dropped  = drp;
         s1_in.ready    = rdy_in;
         s1_in.rd_hit   = hit;
         s1_in.rd_bank  = ~bank_ff;
      end else if (advance) begin
         s1_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         bank_ff     <= 1'b0;
         rdy_ff      <= 1'b0;
         s1_ff.valid <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         rdy_ff  <= rdy_in;
         s1_ff   <= s1_in;
      end
   end

   flrx_ram #(.WIDTH(8), .DEPTH(FRAME_LEN)) u_bank0 (
      .clock (clock),
      .we    (we && !bank_ff),
      .waddr (fill_ff),
      .wdata (req.rx_byte),
      .re    (hit && bank_ff),
      .raddr (raddr),
      .rdata (rdata0)
   );

   flrx_ram #(.WIDTH(8), .DEPTH(FRAME_LEN)) u_bank1 (
      .clock (clock),
      .we    (we && bank_ff),
      .waddr (fill_ff),
      .wdata (req.rx_byte),
      .re    (hit && !bank_ff),
      .raddr (raddr),
      .rdata (rdata1)
   );

   assign stage = s1_ff;

   `FLRX_ASSERT_NEXT(a_swap_on_accept, clock, reset, acc, bank_ff != $past(bank_ff), "bank not swapped after good frame")
   `FLRX_ASSERT_NEXT(a_ready_on_accept, clock, reset, acc, rdy_ff, "ready flag not set after good frame")
   `FLRX_ASSERT_NEXT(a_fill_wraps, clock, reset, we && fill_ff == LAST_FILL, fill_ff == '0, "fill count did not wrap at frame end")
   `FLRX_ASSERT_NEXT(a_fill_holds, clock, reset, !we, $stable(fill_ff), "fill count moved without a stored byte")
   `FLRX_ASSERT(a_flags_exclusive, clock, reset, !(s1_ff.valid && s1_ff.accepted && s1_ff.dropped), "beat both accepted and dropped")

endmodule

// File: sv/flrx_out.sv
module flrx_out (
   input  logic                clock,
   input  logic                reset,
   input  flrx_pkg::stage_type stage,
   input  logic [7:0]          rdata0,
   input  logic [7:0]          rdata1,
   output logic                advance,
   flrx_rsp_if.source          rsp
);
   import flrx_pkg::*;

   logic       valid_ff, valid_in;
   logic       acc_ff, acc_in;
   logic       drp_ff, drp_in;
   logic [7:0] data_ff, data_in;
   logic       rdy_ff, rdy_in;
   logic [7:0] rd_byte;

   assign advance = !valid_ff || rsp.ready;
   assign rd_byte = stage.rd_bank ? rdata1 : rdata0;

   always_comb begin
      valid_in = valid_ff;
      acc_in   = acc_ff;
      drp_in   = drp_ff;
      data_in  = data_ff;
      rdy_in   = rdy_ff;
      if (advance) begin
         valid_in = stage.valid;
         acc_in   = stage.accepted;
         drp_in   = stage.dropped;
         data_in  = stage.rd_hit ? rd_byte : 8'd0;
         rdy_in   = stage.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      acc_ff  <= acc_in;
      drp_ff  <= drp_in;
      data_ff <= data_in;
      rdy_ff  <= rdy_in;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.frame_accepted = acc_ff;
   assign rsp.frame_dropped  = drp_ff;
   assign rsp.read_data      = data_ff;
   assign rsp.packet_ready   = rdy_ff;

endmodule

// File: sv/fixed_length_frame_receiver.sv
// channel   handshake          payload
// req_bus   valid / ready      operation, rx_byte, read_index
// rsp_bus   valid / ready      frame_accepted, frame_dropped, read_data, packet_ready
// csr_*     apb, pready tied   head_byte at 0x0, tail_byte at 0x4
//
// one beat per cycle while rsp_bus is not stalled; each result passes the registered read
// of the frame bank memories, beside the state stage, and then the output register
// two frame banks swap on a good frame, so no step copies the held packet
// reset is synchronous and clears fill count, bank select, ready flag and valids
// a stalled rsp_bus holds one beat in the output and one in the state stage
module fixed_length_frame_receiver (
   input  logic                                clock,
   input  logic                                reset,
   flrx_req_if.sink                            req_bus,
   flrx_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [flrx_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [flrx_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [flrx_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import flrx_pkg::*;

   cfg_type    cfg;
   stage_type  stage;
   logic [7:0] rdata0;
   logic [7:0] rdata1;
   logic       advance;

   flrx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   flrx_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .cfg     (cfg),
      .advance (advance),
      .stage   (stage),
      .rdata0  (rdata0),
      .rdata1  (rdata1)
   );

   flrx_out u_out (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .rdata0  (rdata0),
      .rdata1  (rdata1),
      .advance (advance),
      .rsp     (rsp_bus)
   );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import flrx_pkg::*;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam int unsigned NUM_PHASES = 8;
   localparam int unsigned PHASE_BEATS = 125;
   localparam int unsigned CYCLE_LIMIT = 500_000;

   typedef struct packed {
      logic       accepted;
      logic       dropped;
      logic [7:0] data;
      logic       ready;
   } rx_status_type;

   // tracks frame assembly and the held packet, queues the status each beat should produce
   class frame_tracker;
      logic [7:0]  head_value;
      logic [7:0]  tail_value;
      logic [7:0]  assembly [FRAME_LEN];
      logic [7:0]  held [FRAME_LEN];
      int unsigned fill;
      bit          packet_ready;
      bit          have_packet;
      rx_status_type pending_status [$];
      int unsigned failures;
      int unsigned frames_taken;
      int unsigned drops;
      int unsigned reads;

      function new();
         head_value = HEAD_RESET;
         tail_value = TAIL_RESET;
         fill = 0;
         packet_ready = 0;
         have_packet = 0;
         failures = 0;
         frames_taken = 0;
         drops = 0;
         reads = 0;
      endfunction

      function void set_register(logic reg_sel, logic [7:0] value);
         if (reg_sel == REG_HEAD)
            head_value = value;
         else
            tail_value = value;
      endfunction

      function void note_beat(logic [1:0] op, logic [7:0] rx, logic [6:0] idx);
         rx_status_type s;
         s = '0;
         case (op)
            OP_RECV: begin
               if (fill == 0 && rx != head_value) begin
                  s.dropped = 1'b1;
               end else begin
                  assembly[fill] = rx;
                  fill++;
                  if (fill == FRAME_LEN) begin
                     if (rx == tail_value) begin
                        held = assembly;
                        packet_ready = 1'b1;
                        have_packet = 1'b1;
                        s.accepted = 1'b1;
                        frames_taken++;
                     end else begin
                        s.dropped = 1'b1;
                     end
                     fill = 0;
                  end
               end
               if (s.dropped)
                  drops++;
            end
            OP_READ: begin
               if (idx < FRAME_LEN)
                  s.data = held[idx];
               reads++;
            end
            OP_RELEASE: packet_ready = 1'b0;
            default: ;
         endcase
         s.ready = packet_ready;
         pending_status.push_back(s);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_status(rx_status_type got);
         rx_status_type want;
         if (pending_status.size() == 0) begin
            $display("%0t: unexpected status beat, expected none actual %h", $time, got);
            failures++;
         end else begin
            want = pending_status.pop_front();
            compare_field("frame_accepted", 8'(want.accepted), 8'(got.accepted));
            compare_field("frame_dropped", 8'(want.dropped), 8'(got.dropped));
            compare_field("read_data", want.data, got.data);
            compare_field("packet_ready", 8'(want.ready), 8'(got.ready));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   flrx_req_if req_bus();
   flrx_rsp_if rsp_bus();

   fixed_length_frame_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_tracker tracker;
   int unsigned  beats_sent = 0;
   int unsigned  gap_pct = 0;
   int unsigned  stall_pct = 0;
   int unsigned  side_pct = 0;
   int unsigned  stall_left = 0;
   bit           calm = 0;
   int unsigned  phase;
   int unsigned  pick;
   logic [7:0]   head_set [4] = '{HEAD_RESET, 8'h00, 8'hFF, 8'h7E};
   logic [7:0]   tail_set [4] = '{TAIL_RESET, 8'hFF, 8'h00, 8'h7E};
   int unsigned  pct_set [3] = '{0, 10, 35};

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.note_beat(req_bus.operation, req_bus.rx_byte, req_bus.read_index);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_status({rsp_bus.frame_accepted, rsp_bus.frame_dropped,
                                  rsp_bus.read_data, rsp_bus.packet_ready});
      end
   end

   // result side backpressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!reset && !calm && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         stall_left <= $urandom_range(12, 0);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_beat(logic [1:0] op, logic [7:0] rx, logic [6:0] idx);
      if (!calm && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(13, 1)) @(negedge clock);
      end
      req_bus.operation  <= op;
      req_bus.rx_byte    <= rx;
      req_bus.read_index <= idx;
      req_bus.valid      <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      if (op != OP_IGNORED)
         beats_sent++;
   endtask

   // waits for a falling edge before it starts, so the previous access has ended
   task automatic write_register(logic reg_sel, logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      tracker.set_register(reg_sel, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.pending_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // reads only once some frame has been held, since the packet store is unwritten before
   task automatic side_op();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel <= 5 && tracker.have_packet)
         send_beat(OP_READ, 8'($urandom), 7'($urandom_range(FRAME_LEN - 1)));
      else if (sel == 9 && tracker.have_packet)
         send_beat(OP_READ, 8'($urandom), 7'($urandom_range(127, FRAME_LEN)));
      else if (sel == 8)
         send_beat(OP_IGNORED, 8'($urandom), 7'($urandom));
      else
         send_beat(OP_RELEASE, 8'($urandom), 7'($urandom));
   endtask

   // continues the frame in progress until it closes or max_bytes are sent
   task automatic send_frame(bit good_tail, int unsigned max_bytes);
      logic [7:0]  rx;
      int unsigned sent;
      sent = 0;
      do begin
         if (tracker.fill == 0)
            rx = tracker.head_value;
         else if (tracker.fill == FRAME_LEN - 1)
            rx = good_tail ? tracker.tail_value
                           : tracker.tail_value ^ 8'($urandom_range(255, 1));
         else begin
            case ($urandom_range(9))
               0: rx = 8'h00;
               1: rx = 8'hFF;
               2: rx = tracker.head_value;
               3: rx = tracker.tail_value;
               default: rx = 8'($urandom);
            endcase
         end
         send_beat(OP_RECV, rx, 7'($urandom));
         sent++;
         if (side_pct != 0 && $urandom_range(99) < side_pct)
            side_op();
      end while (tracker.fill != 0 && sent < max_bytes);
   endtask

   initial begin
      tracker = new();
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.operation  = OP_RECV;
      req_bus.rx_byte    = 8'h00;
      req_bus.read_index = 7'd0;
      rsp_bus.ready      = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: release with nothing held, ignored op, bad heads
      send_beat(OP_RELEASE, 8'h00, 7'd0);
      send_beat(OP_IGNORED, 8'hFF, 7'h7F);
      send_beat(OP_RECV, 8'h00, 7'd0);
      send_beat(OP_RECV, 8'hFF, 7'h7F);
      send_beat(OP_RECV, tracker.head_value ^ 8'h01, 7'd0);
      send_frame(1'b1, FRAME_LEN);
      // read edges and out of range, release twice, read after release
      send_beat(OP_READ, 8'hFF, 7'd0);
      send_beat(OP_READ, 8'h00, 7'(FRAME_LEN - 1));
      send_beat(OP_READ, 8'h00, 7'(FRAME_LEN));
      send_beat(OP_READ, 8'h00, 7'h7F);
      send_beat(OP_RELEASE, 8'hFF, 7'h7F);
      send_beat(OP_RELEASE, 8'h00, 7'd0);
      send_beat(OP_READ, 8'h00, 7'd1);
      send_frame(1'b0, FRAME_LEN);
      send_beat(OP_IGNORED, 8'h00, 7'd0);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase != 0) begin
            drain();
            if (phase < 4) begin
               write_register(REG_HEAD, head_set[phase]);
               write_register(REG_TAIL, tail_set[phase]);
            end else begin
               write_register(REG_HEAD, 8'($urandom));
               write_register(REG_TAIL, 8'($urandom));
            end
         end
         calm      = (phase == NUM_PHASES - 1);
         gap_pct   = pct_set[$urandom_range(2)];
         stall_pct = pct_set[$urandom_range(2)];
         side_pct  = 3 + $urandom_range(20);
         while (beats_sent < (phase + 1) * PHASE_BEATS) begin
            pick = $urandom_range(99);
            if (pick < 60)
               send_frame(1'b1, 255);
            else if (pick < 70)
               send_frame(1'b0, 255);
            else if (pick < 78)
               send_frame(1'b1, $urandom_range(60, 1));
            else if (pick < 88)
               repeat ($urandom_range(5, 1)) send_beat(OP_RECV, 8'($urandom), 7'($urandom));
            else
               repeat ($urandom_range(6, 1)) side_op();
         end
      end

      req_bus.valid <= 1'b0;
      while (tracker.pending_status.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      $display("%0d beats over %0d register settings: %0d frames held, %0d discards, %0d reads",
               beats_sent, NUM_PHASES, tracker.frames_taken, tracker.drops, tracker.reads);
      $display("%0d mismatches", tracker.failures);
      if (tracker.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
